### rtl/path_packet_deframer_defines.svh
// assertion macros shared by the deframer rtl
`ifndef PATH_PACKET_DEFRAMER_DEFINES_SVH
`define PATH_PACKET_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define PPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppd assertion failed");
// consequent must hold in the cycle after the antecedent
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppd assertion failed");
`else
`define PPD_ASSERT_IMPL(lbl, ante, cons)
`define PPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/ppd_pkg.sv
package ppd_pkg;

  // packet layout
  localparam int unsigned SETTING_PACKET_BYTES = 7;
  localparam int unsigned POINTS_HEADER_BYTES  = 6;
  localparam int unsigned POINT_BYTES          = 9;
  localparam int unsigned POINT_X_AT           = 1;
  localparam int unsigned POINT_Y_AT           = 5;

  localparam logic [23:0] HDR_WORD   = 24'hFFFFFD;
  localparam logic [7:0]  STUFF_BYTE = 8'hFD;

  // result kinds
  localparam logic RESULT_SETTING = 1'b0;
  localparam logic RESULT_POINT   = 1'b1;

  // configuration register map (index taken from paddr[2])
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_IDX_SETTING = 1'b0;
  localparam logic REG_IDX_POINTS  = 1'b1;
  localparam logic [7:0] SETTING_CODE_RST = 8'd1;
  localparam logic [7:0] POINTS_CODE_RST  = 8'd2;

  // op queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // one classified byte with what the back has to do with it
  typedef struct packed {
    logic [7:0] data;
    logic       hold_sid;
    logic       emit_set;
    logic       pt_start;
    logic       x_shift;
    logic       y_shift;
    logic       emit_pt;
    logic       last_pt;
  } op_t;

endpackage

### rtl/ppd_if.sv
interface ppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ppd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  setting_id;
  logic [7:0]  setting_value;
  logic [7:0]  point_type;
  logic [31:0] point_x_raw;
  logic [31:0] point_y_raw;
  logic        last_point;

  modport source (
    output valid, output result_kind, output setting_id, output setting_value,
    output point_type, output point_x_raw, output point_y_raw, output last_point,
    input ready
  );
  modport sink (
    input valid, input result_kind, input setting_id, input setting_value,
    input point_type, input point_x_raw, input point_y_raw, input last_point,
    output ready
  );
endinterface

### rtl/ppd_queue.sv
`include "path_packet_deframer_defines.svh"

module ppd_queue import ppd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output op_t  head_op
);

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `PPD_ASSERT_IMPL(a_q_no_overflow, push, !full || pop)
  `PPD_ASSERT_IMPL(a_q_no_underflow, pop, cnt_r != '0)

endmodule

### rtl/ppd_front.sv
`include "path_packet_deframer_defines.svh"

module ppd_front import ppd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ppd_in_if.sink     in_ch,
  input  logic [7:0] setting_code,
  input  logic [7:0] points_code,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_SET_ID, PH_SET_VAL, PH_COUNT, PH_SKIP, PH_POINTS
  } phase_t;

  localparam logic [3:0] SET_SKIP = 4'(SETTING_PACKET_BYTES - 7);
  localparam logic [3:0] PTS_SKIP = 4'(POINTS_HEADER_BYTES - 6);
  localparam logic [4:0] X_LO     = 5'(POINT_X_AT);
  localparam logic [4:0] X_HI     = 5'(POINT_X_AT + 4);
  localparam logic [4:0] Y_LO     = 5'(POINT_Y_AT);
  localparam logic [4:0] Y_HI     = 5'(POINT_Y_AT + 4);
  localparam logic [4:0] LAST_OFF = 5'(POINT_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [23:0] win_r, win_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  pts_r, pts_nxt;
  logic        accept;
  logic [7:0]  b;
  logic [4:0]  off;
  logic [3:0]  pos_dec;
  logic [7:0]  pts_dec;
  op_t         op;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;
  assign off         = {1'b0, pos_r};
  assign pos_dec     = pos_r - 1'b1;
  assign pts_dec     = pts_r - 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    pos_nxt   = pos_r;
    pts_nxt   = pts_r;
    op        = '0;
    op.data   = b;
    case (phase_r)
      PH_TYPE: begin
        win_nxt = {win_r[15:0], b};
        if (b == setting_code) begin
          phase_nxt = PH_SET_ID;
        end else if (b == points_code) begin
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SET_ID: begin
        op.hold_sid = 1'b1;
        phase_nxt   = PH_SET_VAL;
      end
      PH_SET_VAL: begin
        op.emit_set = 1'b1;
        pts_nxt     = '0;
        if (SET_SKIP != '0) begin
          phase_nxt = PH_SKIP;
          pos_nxt   = SET_SKIP;
        end else begin
          phase_nxt = PH_HUNT;
          win_nxt   = '0;
          pos_nxt   = '0;
        end
      end
      PH_COUNT: begin
        pts_nxt = b;
        if (PTS_SKIP != '0) begin
          phase_nxt = PH_SKIP;
          pos_nxt   = PTS_SKIP;
        end else if (b != '0) begin
          phase_nxt = PH_POINTS;
          pos_nxt   = '0;
        end else begin
          phase_nxt = PH_HUNT;
          win_nxt   = '0;
          pos_nxt   = '0;
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_dec;
        if (pos_dec == '0) begin
          if (pts_r != '0) begin
            phase_nxt = PH_POINTS;
          end else begin
            phase_nxt = PH_HUNT;
            win_nxt   = '0;
            pts_nxt   = '0;
          end
        end
      end
      PH_POINTS: begin
        op.pt_start = (off == '0);
        op.x_shift  = (off >= X_LO) && (off < X_HI);
        op.y_shift  = (off >= Y_LO) && (off < Y_HI);
        if (off >= LAST_OFF) begin
          op.emit_pt = 1'b1;
          op.last_pt = (pts_dec == '0);
          pts_nxt    = pts_dec;
          pos_nxt    = '0;
          if (pts_dec == '0) begin
            phase_nxt = PH_HUNT;
            win_nxt   = '0;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: begin
        // hunting, also any unused phase code
        if (win_r == HDR_WORD && b != STUFF_BYTE) begin
          phase_nxt = PH_TYPE;
        end else begin
          phase_nxt = PH_HUNT;
        end
        win_nxt = {win_r[15:0], b};
      end
    endcase
  end

  assign push    = accept && (op.hold_sid || op.emit_set || op.pt_start ||
                              op.x_shift || op.y_shift || op.emit_pt);
  assign push_op = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      pos_r   <= '0;
      pts_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      pts_r   <= pts_nxt;
    end
  end

  `PPD_ASSERT_IMPL(a_points_pending, phase_r == PH_POINTS, pts_r != '0)

endmodule

### rtl/ppd_back.sv
`include "path_packet_deframer_defines.svh"

module ppd_back import ppd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  op_t     head_op,
  output logic    pop,
  ppd_out_if.source out_ch
);

  logic [7:0]  sid_r;
  logic [7:0]  ptype_r, ptype_nxt;
  logic [31:0] x_r, x_nxt, x_base;
  logic [31:0] y_r, y_nxt, y_base;
  logic        emits;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r;
  logic [7:0]  out_sid_r;
  logic [7:0]  out_val_r;
  logic [7:0]  out_ptype_r;
  logic [31:0] out_x_r;
  logic [31:0] out_y_r;
  logic        out_last_r;
  logic        set_beat;

  assign emits = head_op.emit_set || head_op.emit_pt;
  // output register frees up when empty or taken this cycle
  assign pop   = head_valid && (!emits || !out_valid_r || out_ch.ready);

  always_comb begin
    x_base    = head_op.pt_start ? '0 : x_r;
    y_base    = head_op.pt_start ? '0 : y_r;
    x_nxt     = head_op.x_shift ? {x_base[23:0], head_op.data} : x_base;
    y_nxt     = head_op.y_shift ? {y_base[23:0], head_op.data} : y_base;
    ptype_nxt = head_op.pt_start ? head_op.data : ptype_r;
  end

  always_comb begin
    if (pop && emits) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_op.hold_sid) begin
        sid_r <= head_op.data;
      end
      ptype_r <= ptype_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      if (head_op.emit_set) begin
        out_kind_r  <= RESULT_SETTING;
        out_sid_r   <= sid_r;
        out_val_r   <= head_op.data;
        out_ptype_r <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_last_r  <= 1'b0;
      end else if (head_op.emit_pt) begin
        out_kind_r  <= RESULT_POINT;
        out_sid_r   <= '0;
        out_val_r   <= '0;
        out_ptype_r <= ptype_nxt;
        out_x_r     <= x_nxt;
        out_y_r     <= y_nxt;
        out_last_r  <= head_op.last_pt;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.setting_id    = out_sid_r;
  assign out_ch.setting_value = out_val_r;
  assign out_ch.point_type    = out_ptype_r;
  assign out_ch.point_x_raw   = out_x_r;
  assign out_ch.point_y_raw   = out_y_r;
  assign out_ch.last_point    = out_last_r;

  // setting beat on the output
  assign set_beat = out_valid_r && (out_kind_r == RESULT_SETTING);

  `PPD_ASSERT_IMPL(a_setting_clean, set_beat, out_x_r == '0 && out_y_r == '0 && !out_last_r)

endmodule

### rtl/path_packet_deframer.sv
// a result reaches out_ch through the op queue and then the back's output register
// throughput: one byte beat per cycle while the op queue is not full, set by the front parser
// a four-entry op queue lets the parser run on while a result waits to be taken
// reset: synchronous active-low rst_n returns the parser to header hunt, empties the
// queue and output register, and sets the type codes to 1 (setting) and 2 (points)
module path_packet_deframer import ppd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ppd_in_if.sink                in_ch,
  ppd_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // type code registers
  logic [7:0] set_code_r, set_code_nxt;
  logic [7:0] pts_code_r, pts_code_nxt;
  logic       cfg_wr;
  logic       reg_idx;

  // front to queue, queue to back
  logic q_push;
  op_t  q_push_op;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  op_t  q_head_op;

  // apb: no wait states, write lands on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    set_code_nxt = set_code_r;
    pts_code_nxt = pts_code_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_IDX_SETTING: set_code_nxt = cfg_pwdata[7:0];
        REG_IDX_POINTS:  pts_code_nxt = cfg_pwdata[7:0];
        default: begin
          set_code_nxt = set_code_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IDX_SETTING: cfg_prdata = {24'b0, set_code_r};
      REG_IDX_POINTS:  cfg_prdata = {24'b0, pts_code_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_code_r <= SETTING_CODE_RST;
      pts_code_r <= POINTS_CODE_RST;
    end else begin
      set_code_r <= set_code_nxt;
      pts_code_r <= pts_code_nxt;
    end
  end

  // front: header hunt and packet walk, tags every byte with its job
  ppd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .setting_code (set_code_r),
    .points_code  (pts_code_r),
    .q_full       (q_full),
    .push         (q_push),
    .push_op      (q_push_op)
  );

  // only bytes that carry work enter the queue
  ppd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // back: word assembly and the registered result beat
  ppd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

### tb/path_packet_deframer_tb.sv
`timescale 1ns / 1ps

import ppd_pkg::*;

typedef enum logic [2:0] {
  HUNT, TYPE_BYTE, SETTING_ID, SETTING_VALUE, COUNT_BYTE, PADDING, POINT_DATA
} parse_phase_t;

typedef struct packed {
  logic        result_kind;
  logic [7:0]  setting_id;
  logic [7:0]  setting_value;
  logic [7:0]  point_type;
  logic [31:0] point_x_raw;
  logic [31:0] point_y_raw;
  logic        last_point;
} frame_result_t;

// tracks the deframer state byte by byte and holds the results it owes
class frame_scoreboard;
  logic [7:0]    setting_code;
  logic [7:0]    points_code;
  logic [23:0]   window;
  parse_phase_t  phase;
  logic [3:0]    pos;
  logic [7:0]    points_left;
  logic [7:0]    held_id;
  logic [7:0]    held_type;
  logic [31:0]   x_acc;
  logic [31:0]   y_acc;
  frame_result_t owed_results[$];
  int unsigned   fails;

  function new();
    setting_code = SETTING_CODE_RST;
    points_code  = POINTS_CODE_RST;
    window       = '0;
    phase        = HUNT;
    pos          = '0;
    points_left  = '0;
    held_id      = '0;
    held_type    = '0;
    x_acc        = '0;
    y_acc        = '0;
    fails        = 0;
  endfunction

  function void set_code(logic idx, logic [31:0] data);
    if (idx == REG_IDX_SETTING) setting_code = data[7:0];
    else points_code = data[7:0];
  endfunction

  function void close_packet();
    window      = '0;
    phase       = HUNT;
    pos         = '0;
    points_left = '0;
  endfunction

  // after the fixed header: any padding, then points or back to the hunt
  function void after_header(int unsigned fixed_len, int unsigned total_len);
    if (total_len > fixed_len) begin
      phase = PADDING;
      pos   = 4'(total_len - fixed_len);
    end else if (points_left != 0) begin
      phase = POINT_DATA;
      pos   = '0;
    end else begin
      close_packet();
    end
  endfunction

  function void note_byte(logic [7:0] b);
    frame_result_t r;
    int unsigned   off;
    r = '0;
    case (phase)
      TYPE_BYTE: begin
        window = {window[15:0], b};
        if (b == setting_code) phase = SETTING_ID;
        else if (b == points_code) phase = COUNT_BYTE;
        else phase = HUNT;
      end
      SETTING_ID: begin
        held_id = b;
        phase   = SETTING_VALUE;
      end
      SETTING_VALUE: begin
        r.result_kind   = RESULT_SETTING;
        r.setting_id    = held_id;
        r.setting_value = b;
        owed_results.push_back(r);
        points_left = '0;
        after_header(7, SETTING_PACKET_BYTES);
      end
      COUNT_BYTE: begin
        points_left = b;
        after_header(6, POINTS_HEADER_BYTES);
      end
      PADDING: begin
        pos = pos - 4'd1;
        if (pos == 0) begin
          if (points_left != 0) phase = POINT_DATA;
          else close_packet();
        end
      end
      POINT_DATA: begin
        off = pos;
        if (off == 0) begin
          held_type = b;
          x_acc     = '0;
          y_acc     = '0;
        end
        if (off >= POINT_X_AT && off < POINT_X_AT + 4) x_acc = {x_acc[23:0], b};
        if (off >= POINT_Y_AT && off < POINT_Y_AT + 4) y_acc = {y_acc[23:0], b};
        if (off >= POINT_BYTES - 1) begin
          points_left   = points_left - 8'd1;
          r.result_kind = RESULT_POINT;
          r.point_type  = held_type;
          r.point_x_raw = x_acc;
          r.point_y_raw = y_acc;
          r.last_point  = (points_left == 0);
          owed_results.push_back(r);
          pos = '0;
          if (points_left == 0) close_packet();
        end else begin
          pos = 4'(off + 1);
        end
      end
      default: begin
        if (window == HDR_WORD && b != STUFF_BYTE) phase = TYPE_BYTE;
        else phase = HUNT;
        window = {window[15:0], b};
      end
    endcase
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fails++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual %0h", $time, got);
      fails++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    compare_field("setting_id", 32'(want.setting_id), 32'(got.setting_id));
    compare_field("setting_value", 32'(want.setting_value), 32'(got.setting_value));
    compare_field("point_type", 32'(want.point_type), 32'(got.point_type));
    compare_field("point_x_raw", want.point_x_raw, got.point_x_raw);
    compare_field("point_y_raw", want.point_y_raw, got.point_y_raw);
    compare_field("last_point", 32'(want.last_point), 32'(got.last_point));
  endfunction
endclass

module path_packet_deframer_tb;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  ppd_in_if  in_ch ();
  ppd_out_if out_ch ();

  frame_scoreboard sb;

  // calm: neither side idles; want_hold: ask the receiver for one long hold-off
  bit          calm = 1'b0;
  bit          want_hold = 1'b0;
  int unsigned bytes_sent = 0;

  path_packet_deframer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // byte channel driver, always entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    // random gaps before the beat, none in calm stretches
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sync word, reserved byte (never the stuffing byte) and type byte
  task automatic send_header(input logic [7:0] type_byte);
    logic [7:0] rsv;
    do rsv = 8'($urandom_range(255)); while (rsv == STUFF_BYTE);
    send_byte(HDR_WORD[23:16]);
    send_byte(HDR_WORD[15:8]);
    send_byte(HDR_WORD[7:0]);
    send_byte(rsv);
    send_byte(type_byte);
  endtask

  task automatic send_setting(input logic [7:0] id, input logic [7:0] value);
    send_header(sb.setting_code);
    send_byte(id);
    send_byte(value);
    repeat (SETTING_PACKET_BYTES - 7) send_byte(8'($urandom_range(255)));
  endtask

  // one point: filler bytes are random, the type and words land at their offsets
  task automatic send_point(input logic [7:0] ptype, input logic [31:0] x,
                            input logic [31:0] y);
    logic [7:0] b;
    for (int i = 0; i < POINT_BYTES; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0) b = ptype;
      if (i >= POINT_X_AT && i < POINT_X_AT + 4) b = x[8*(3-(i-POINT_X_AT)) +: 8];
      if (i >= POINT_Y_AT && i < POINT_Y_AT + 4) b = y[8*(3-(i-POINT_Y_AT)) +: 8];
      send_byte(b);
    end
  endtask

  task automatic send_points(input int unsigned count);
    send_header(sb.points_code);
    send_byte(count[7:0]);
    repeat (POINTS_HEADER_BYTES - 6) send_byte(8'($urandom_range(255)));
    repeat (count) send_point(8'($urandom_range(255)), $urandom, $urandom);
  endtask

  // line noise biased toward the sync bytes
  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(3))
        0: send_byte(8'hFF);
        1: send_byte(STUFF_BYTE);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // malformed frames: stuffed sync, unknown type, or a packet cut short
  task automatic send_broken();
    logic [7:0] t;
    case ($urandom_range(2))
      0: begin
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(STUFF_BYTE);
        send_byte(STUFF_BYTE);
      end
      1: begin
        do t = 8'($urandom_range(255));
        while (t == sb.setting_code || t == sb.points_code);
        send_header(t);
      end
      default: begin
        send_header($urandom_range(1) ? sb.setting_code : sb.points_code);
        send_noise($urandom_range(3));
      end
    endcase
  endtask

  // mostly well-formed packets with random content, some noise and broken frames
  task automatic send_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 45) send_setting(8'($urandom_range(255)), 8'($urandom_range(255)));
      else if (pick < 80)
        send_points(($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(3));
      else if (pick < 90) send_broken();
      else send_noise($urandom_range(1, 6));
    end
  endtask

  // drop valid, let every owed result drain, then give the pipe time to empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // config port: write then read back the same register
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_code(idx, data);
    @(negedge clk);
    // read setup
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== data[7:0]) begin
      $display("%0t: readback of register %0d mismatch, expected %0h, actual %0h",
               $time, idx, data[7:0], cfg_prdata[7:0]);
      sb.fails++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // upper data bits are junk the block must ignore
  task automatic write_codes(input logic [7:0] set_code, input logic [7:0] pts_code);
    cfg_write(REG_IDX_SETTING, ($urandom & 32'hFFFF_FF00) | 32'(set_code));
    cfg_write(REG_IDX_POINTS, ($urandom & 32'hFFFF_FF00) | 32'(pts_code));
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned   hold_left;
    frame_result_t got;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind   = out_ch.result_kind;
        got.setting_id    = out_ch.setting_id;
        got.setting_value = out_ch.setting_value;
        got.point_type    = out_ch.point_type;
        got.point_x_raw   = out_ch.point_x_raw;
        got.point_y_raw   = out_ch.point_y_raw;
        got.last_point    = out_ch.last_point;
        sb.check_result(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] s_code;
    logic [7:0] p_code;

    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    sb = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset type codes
    // setting packets with extreme id and value
    send_setting(8'hFF, 8'h00);
    send_setting(8'h00, 8'hFF);
    // stuffed sync is not a header, then an empty points packet
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(STUFF_BYTE);
    send_byte(STUFF_BYTE);
    send_points(0);
    // single point with all-ones x and zero y, flagged as last
    send_header(sb.points_code);
    send_byte(8'd1);
    repeat (POINTS_HEADER_BYTES - 6) send_byte(8'h00);
    send_point(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    // unknown type byte that is itself the start of the next header
    send_header(8'hFF);
    send_byte(8'hFF);
    send_byte(STUFF_BYTE);
    send_byte(8'h00);
    send_byte(sb.setting_code);
    send_byte(8'h12);
    send_byte(8'h34);
    // sync tail right after a finished packet must not open a new one
    send_setting(8'hFF, 8'hFF);
    send_byte(STUFF_BYTE);
    send_byte(8'h00);
    send_byte(sb.setting_code);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_traffic(30);

    // lowest and highest codes
    settle();
    write_codes(8'h00, 8'hFF);
    send_traffic(50);

    // equal codes: a matching type byte is a setting
    settle();
    write_codes(8'h07, 8'h07);
    send_traffic(30);

    // swapped extremes, no idling on either side
    settle();
    calm = 1'b1;
    write_codes(8'hFF, 8'h00);
    send_traffic(50);
    calm = 1'b0;

    // random distinct codes; long receiver hold-off over a long points packet
    settle();
    s_code = 8'($urandom_range(255));
    do p_code = 8'($urandom_range(255)); while (p_code == s_code);
    write_codes(s_code, p_code);
    send_traffic(30);
    want_hold = 1'b1;
    send_points(20);
    send_traffic(30);

    // back to the reset codes
    settle();
    write_codes(SETTING_CODE_RST, POINTS_CODE_RST);
    send_traffic(30);

    // drain and let the output path go quiet
    settle();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
